// ===== rtl/snz_pkg.sv =====
package snz_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NOISE_W = 22;
  localparam int GRAD_W = 23;
  localparam int TERM_W = 29;

  localparam logic [30:0] K1_Q32 = 31'd1572067140;
  localparam logic [29:0] K2_Q32 = 30'd907633384;

  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [4:0] lz;
    lz = 5'd31;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        lz = 5'(31 - i);
      end
    end
    return lz;
  endfunction

  function automatic logic [31:0] hash_lo(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x + (x << 10);
    b = a ^ (a >> 6);
    return b + (b << 3);
  endfunction

  function automatic logic [31:0] hash_hi(input logic [31:0] x);
    logic [31:0] a;
    a = x ^ (x >> 11);
    return a + (a << 15);
  endfunction

endpackage

// ===== rtl/snz_grad.sv =====
module snz_grad #(
  parameter int CW = 18
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [CW-1:0]        coord,
  output logic [snz_pkg::GRAD_W-1:0]  grad
);
  import snz_pkg::*;

  logic [31:0] mag1_r;
  logic        neg1_r;
  logic [31:0] mag2_r;
  logic        neg2_r;
  logic [4:0]  lz2_r;
  logic [31:0] fbits3_r;
  logic [31:0] hl4_r;
  logic [GRAD_W-1:0] grad_r;

  logic [31:0] cext;
  logic [31:0] norm;
  logic [7:0]  expo;
  logic [31:0] hfull;

  assign cext = 32'(coord);
  assign norm = mag2_r << lz2_r;
  assign expo = 8'd158 - {3'b000, lz2_r};
  assign hfull = hash_hi(hl4_r);

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r   <= coord[CW-1];
      mag1_r   <= coord[CW-1] ? (32'd0 - cext) : cext;
      neg2_r   <= neg1_r;
      mag2_r   <= mag1_r;
      lz2_r    <= lzc32(mag1_r);
      fbits3_r <= (mag2_r == 32'd0) ? 32'd0 : {neg2_r, expo, norm[30:8]};
      hl4_r    <= hash_lo(fbits3_r);
      grad_r   <= hfull[GRAD_W-1:0];
    end
  end

  assign grad = grad_r;

endmodule

// ===== rtl/snz_corner.sv =====
module snz_corner #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [FRAC_BITS+3:0]       dx,
  input  logic signed [FRAC_BITS+3:0]       dy,
  input  logic [snz_pkg::GRAD_W-1:0]        gx,
  input  logic [snz_pkg::GRAD_W-1:0]        gy,
  output logic signed [snz_pkg::TERM_W-1:0] term
);
  import snz_pkg::*;

  localparam int F = FRAC_BITS;
  localparam int DW = F + 4;
  localparam int PW = DW + GRAD_W + 1;
  localparam logic [2*DW:0] HALF = (2*DW+1)'(1) << (2*F - 1);

  logic signed [DW-1:0] dx1_r, dy1_r, dx2_r, dy2_r, dx3_r, dy3_r;
  logic signed [DW-1:0] dx4_r, dy4_r, dx5_r, dy5_r;
  logic [2*DW-1:0] sqx2_r, sqy2_r;
  logic [28:0] h30_3_r;
  logic pos3_r, pos4_r, pos5_r, pos6_r;
  logic [57:0] hsq4_r;
  logic [55:0] h2sq5_r;
  logic [25:0] h4_6_r, h4_7_r;
  logic signed [PW-1:0] pxg6_r, pyg6_r;
  logic signed [31:0] dt7_r;
  logic signed [58:0] prod8_r;

  logic [2*DW:0] d2;
  logic [2*DW:0] hdiff;
  logic pos;
  logic [2*F+28:0] hsh;
  logic [27:0] h2;
  logic signed [PW:0] dsum;

  assign d2 = {1'b0, sqx2_r} + {1'b0, sqy2_r};
  assign pos = d2 < HALF;
  assign hdiff = HALF - d2;
  assign hsh = {hdiff[2*F-2:0], 30'd0};
  assign h2 = hsq4_r[57:30];
  assign dsum = {pxg6_r[PW-1], pxg6_r} + {pyg6_r[PW-1], pyg6_r};

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r   <= dx;
      dy1_r   <= dy;
      dx2_r   <= dx1_r;
      dy2_r   <= dy1_r;
      sqx2_r  <= $unsigned((2*DW)'(dx1_r * dx1_r));
      sqy2_r  <= $unsigned((2*DW)'(dy1_r * dy1_r));
      dx3_r   <= dx2_r;
      dy3_r   <= dy2_r;
      pos3_r  <= pos;
      h30_3_r <= pos ? hsh[2*F+28:2*F] : 29'd0;
      dx4_r   <= dx3_r;
      dy4_r   <= dy3_r;
      pos4_r  <= pos3_r;
      hsq4_r  <= {29'd0, h30_3_r} * {29'd0, h30_3_r};
      dx5_r   <= dx4_r;
      dy5_r   <= dy4_r;
      pos5_r  <= pos4_r;
      h2sq5_r <= {28'd0, h2} * {28'd0, h2};
      pos6_r  <= pos5_r;
      h4_6_r  <= h2sq5_r[55:30];
      pxg6_r  <= PW'(dx5_r * $signed({1'b0, gx}));
      pyg6_r  <= PW'(dy5_r * $signed({1'b0, gy}));
      h4_7_r  <= h4_6_r;
      dt7_r   <= pos6_r ? $signed(dsum[F+24:F-7]) : 32'sd0;
      prod8_r <= 59'(dt7_r * $signed({1'b0, h4_7_r}));
    end
  end

  assign term = prod8_r[58:30];

endmodule

// ===== rtl/simplex_noise_2d.sv =====
// Channel  Direction  Ports                            Payload
// in       input      in_valid, in_ready               in_px, in_py (signed Q15.16)
// out      output     out_valid, out_ready             out_noise_value (signed Q5.16)
//
// One item is accepted per cycle unless the last stage holds a result that out_ready does not take.
// The pipeline has 14 stages: lattice, gradient hash, falloff, then the final scale and clamp.
// Reset clears only the stage valid bits.
// A stall at the output freezes every stage at once, so nothing is lost or repeated.
module simplex_noise_2d #(
  parameter int FRAC_BITS = snz_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [31:0]                 in_px,
  input  logic signed [31:0]                 in_py,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [snz_pkg::NOISE_W-1:0] out_noise_value
);
  import snz_pkg::*;

  localparam int F = FRAC_BITS;
  localparam int IW = 33 - F;
  localparam int CW = IW + 1;
  localparam int DW = F + 4;
  localparam int MW = CW + 31;
  localparam int NSTG = 14;
  localparam logic signed [DW-1:0] ONE = DW'(64'd1 << F);
  localparam logic signed [DW-1:0] K2F =
    DW'((64'(K2_Q32) + (64'd1 << (31 - F))) >> (32 - F));
  localparam logic signed [37:0] RND = 38'sd1 <<< (29 - F);
  localparam logic signed [37:0] NMAX = 38'sd2097151;
  localparam logic signed [37:0] NMIN = -38'sd2097152;

  logic en;
  logic [NSTG-1:0] vld_r, vld_nxt;

  logic signed [31:0] px_a_r, py_a_r, px_b_r, py_b_r, px_c_r, py_c_r, px_d_r, py_d_r;
  logic signed [64:0] prod_b_r;
  logic signed [IW-1:0] ix_c_r, iy_c_r, ix_d_r, iy_d_r, ix_e_r, iy_e_r;
  logic signed [MW-1:0] prod_d_r;
  logic signed [DW-1:0] ax_e_r, ay_e_r;
  logic sel_y_e_r;
  logic signed [NOISE_W-1:0] noise_r;

  logic signed [32:0] sum_xy, pxs, pys;
  logic signed [31:0] s_val;
  logic signed [IW:0] ij;
  logic signed [DW-1:0] t_lo, ax, ay, bx, by, cx, cy;
  logic signed [CW-1:0] ixe, iye, ix1, iy1, ixo, iyo;
  logic [GRAD_W-1:0] gx0, gy0, gx1, gy1, gx2, gy2;
  logic signed [TERM_W-1:0] term0, term1, term2;
  logic signed [30:0] tsum;
  logic signed [37:0] s70, rnd_v;

  assign en = ~vld_r[NSTG-1] | out_ready;
  assign in_ready = en;
  assign vld_nxt = {vld_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  assign sum_xy = {px_a_r[31], px_a_r} + {py_a_r[31], py_a_r};
  assign s_val = prod_b_r[63:32];
  assign pxs = {px_b_r[31], px_b_r} + {s_val[31], s_val};
  assign pys = {py_b_r[31], py_b_r} + {s_val[31], s_val};
  assign ij = {ix_c_r[IW-1], ix_c_r} + {iy_c_r[IW-1], iy_c_r};
  assign t_lo = prod_d_r[DW+31-F:32-F];
  assign ax = px_d_r[DW-1:0] - {ix_d_r[3:0], {F{1'b0}}} + t_lo;
  assign ay = py_d_r[DW-1:0] - {iy_d_r[3:0], {F{1'b0}}} + t_lo;

  always_ff @(posedge clk) begin
    if (en) begin
      px_a_r    <= in_px;
      py_a_r    <= in_py;
      px_b_r    <= px_a_r;
      py_b_r    <= py_a_r;
      prod_b_r  <= 65'(sum_xy * $signed({1'b0, K1_Q32}));
      px_c_r    <= px_b_r;
      py_c_r    <= py_b_r;
      ix_c_r    <= pxs[32:F];
      iy_c_r    <= pys[32:F];
      px_d_r    <= px_c_r;
      py_d_r    <= py_c_r;
      ix_d_r    <= ix_c_r;
      iy_d_r    <= iy_c_r;
      prod_d_r  <= MW'(ij * $signed({1'b0, K2_Q32}));
      ix_e_r    <= ix_d_r;
      iy_e_r    <= iy_d_r;
      ax_e_r    <= ax;
      ay_e_r    <= ay;
      sel_y_e_r <= ay > ax;
    end
  end

  assign bx = ax_e_r - (sel_y_e_r ? DW'(0) : ONE) + K2F;
  assign by = ay_e_r - (sel_y_e_r ? ONE : DW'(0)) + K2F;
  assign cx = ax_e_r - ONE + K2F + K2F;
  assign cy = ay_e_r - ONE + K2F + K2F;
  assign ixe = {ix_e_r[IW-1], ix_e_r};
  assign iye = {iy_e_r[IW-1], iy_e_r};
  assign ix1 = ixe + CW'(1);
  assign iy1 = iye + CW'(1);
  assign ixo = sel_y_e_r ? ixe : ix1;
  assign iyo = sel_y_e_r ? iy1 : iye;

  snz_grad #(.CW(CW)) u_gx0 (.clk(clk), .en(en), .coord(ixe), .grad(gx0));
  snz_grad #(.CW(CW)) u_gy0 (.clk(clk), .en(en), .coord(iye), .grad(gy0));
  snz_grad #(.CW(CW)) u_gx1 (.clk(clk), .en(en), .coord(ixo), .grad(gx1));
  snz_grad #(.CW(CW)) u_gy1 (.clk(clk), .en(en), .coord(iyo), .grad(gy1));
  snz_grad #(.CW(CW)) u_gx2 (.clk(clk), .en(en), .coord(ix1), .grad(gx2));
  snz_grad #(.CW(CW)) u_gy2 (.clk(clk), .en(en), .coord(iy1), .grad(gy2));

  snz_corner #(.FRAC_BITS(F)) u_c0 (
    .clk(clk), .en(en), .dx(ax_e_r), .dy(ay_e_r), .gx(gx0), .gy(gy0), .term(term0)
  );
  snz_corner #(.FRAC_BITS(F)) u_c1 (
    .clk(clk), .en(en), .dx(bx), .dy(by), .gx(gx1), .gy(gy1), .term(term1)
  );
  snz_corner #(.FRAC_BITS(F)) u_c2 (
    .clk(clk), .en(en), .dx(cx), .dy(cy), .gx(gx2), .gy(gy2), .term(term2)
  );

  assign tsum = 31'(term0) + 31'(term1) + 31'(term2);
  assign s70 = (38'(tsum) <<< 6) + (38'(tsum) <<< 2) + (38'(tsum) <<< 1);
  assign rnd_v = (s70 + RND) >>> (30 - F);

  always_ff @(posedge clk) begin
    if (en) begin
      if (rnd_v > NMAX) begin
        noise_r <= NMAX[NOISE_W-1:0];
      end else if (rnd_v < NMIN) begin
        noise_r <= NMIN[NOISE_W-1:0];
      end else begin
        noise_r <= rnd_v[NOISE_W-1:0];
      end
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_noise_value = noise_r;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int FB = snz_pkg::FRAC_BITS_DEF;
  localparam longint K1C = 64'd1572067140;
  localparam longint K2C = 64'd907633384;
  localparam int PIPE_LAT = 14;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_px = '0;
  logic signed [31:0] in_py = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [snz_pkg::NOISE_W-1:0] out_noise_value;
  logic in_taken = 1'b0;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  point_t pending_points[$];
  logic signed [snz_pkg::NOISE_W-1:0] expected_noise[$];
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int error_count = 0;
  int points_sent = 0;
  int results_seen = 0;

  simplex_noise_2d DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_px(in_px), .in_py(in_py),
    .out_valid(out_valid), .out_ready(out_ready), .out_noise_value(out_noise_value)
  );

  always #1 clk = ~clk;

  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic logic [31:0] shift_add_xor(logic [31:0] x);
    x = x + (x << 10);
    x = x ^ (x >> 6);
    x = x + (x << 3);
    x = x ^ (x >> 11);
    x = x + (x << 15);
    return x;
  endfunction

  function automatic logic [31:0] lattice_bits(longint n);
    logic [31:0] sgn;
    longint unsigned mag;
    int e;
    longint unsigned mant;
    if (n == 0) return 32'd0;
    sgn = (n < 0) ? 32'h8000_0000 : 32'd0;
    mag = (n < 0) ? -n : n;
    e = 0;
    while (e < 63 && (mag >> (e + 1)) != 0) e++;
    mant = (e <= 23) ? (mag << (23 - e)) : (mag >> (e - 23));
    return sgn | (32'(127 + e) << 23) | (32'(mant) & 32'h007F_FFFF);
  endfunction

  function automatic longint gradient(longint n);
    return longint'(shift_add_xor(lattice_bits(n)) & 32'h007F_FFFF);
  endfunction

  function automatic longint falloff_term(longint dx, longint dy, longint gx, longint gy);
    longint d2, h, h30, h2, h4, dt;
    d2 = dx * dx + dy * dy;
    h = (longint'(1) << (2 * FB - 1)) - d2;
    if (h <= 0) return 0;
    h30 = (2 * FB >= 30) ? (h >>> (2 * FB - 30)) : (h <<< (30 - 2 * FB));
    h2 = (h30 * h30) >>> 30;
    h4 = (h2 * h2) >>> 30;
    dt = floor_shift(dx * gx + dy * gy, FB + 23 - 30);
    return floor_shift(h4 * dt, 30);
  endfunction

  function automatic logic signed [snz_pkg::NOISE_W-1:0] noise_at(point_t p);
    longint one, k2f, px, py, s, ix, iy, t, ax, ay, ox, oy, bx, by, cx, cy, sum, v;
    one = longint'(1) << FB;
    k2f = (K2C + (longint'(1) << (31 - FB))) >>> (32 - FB);
    px = p.x;
    py = p.y;
    s = floor_shift((px + py) * K1C, 32);
    ix = floor_shift(px + s, FB);
    iy = floor_shift(py + s, FB);
    t = floor_shift((ix + iy) * K2C, 32 - FB);
    ax = px - ix * one + t;
    ay = py - iy * one + t;
    ox = 1;
    oy = 0;
    if (ay > ax) begin
      ox = 0;
      oy = 1;
    end
    bx = ax - ox * one + k2f;
    by = ay - oy * one + k2f;
    cx = ax - one + 2 * k2f;
    cy = ay - one + 2 * k2f;
    sum = falloff_term(ax, ay, gradient(ix), gradient(iy));
    sum += falloff_term(bx, by, gradient(ix + ox), gradient(iy + oy));
    sum += falloff_term(cx, cy, gradient(ix + 1), gradient(iy + 1));
    v = floor_shift(sum * 70 + (longint'(1) << (29 - FB)), 30 - FB);
    if (v > 2097151) v = 2097151;
    if (v < -2097152) v = -2097152;
    return v[snz_pkg::NOISE_W-1:0];
  endfunction

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_points.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          point_t p;
          p = pending_points.pop_front();
          in_valid <= 1'b1;
          in_px <= p.x;
          in_py <= p.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_noise.push_back(noise_at('{in_px, in_py}));
        points_sent++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_noise.size() == 0) begin
          $error("noise_value: unexpected result %0d", out_noise_value);
          error_count++;
        end else begin
          logic signed [snz_pkg::NOISE_W-1:0] want;
          want = expected_noise.pop_front();
          if (want !== out_noise_value) begin
            $error("noise_value: expected %0d, got %0d", want, out_noise_value);
            error_count++;
          end
        end
      end
    end
  end

  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_noise.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [31:0] edge_vals[8];
    edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                  32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h5555_AAAA};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 3; j++)
        pending_points.push_back('{edge_vals[i], edge_vals[(i + 3 * j + 1) % 8]});
    pending_points.push_back('{32'h0000_4000, 32'h0000_4000});
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 75 : 0;
      sink_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 30 : 0;
      for (int k = 0; k < 650; k++) begin
        logic [31:0] a;
        a = random_coord();
        pending_points.push_back('{a, ($urandom_range(0, 9) == 0) ? a : random_coord()});
      end
      drain();
    end
    repeat (PIPE_LAT + 10) @(posedge clk);
    $display("Covered %0d points (edge values, diagonal ties, mixed ranges) and %0d results.",
             points_sent, results_seen);
    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #500000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
